// ----- rtl/cmap_pkg.sv -----
// Shared types, constants and helpers of the interpolated calibration map.
package cmap_pkg;

	localparam int MAX_X_POINTS = 16;
	localparam int MAX_Y_POINTS = 16;
	localparam int IDX_W        = 4;
	localparam int CNT_W        = 5;
	localparam int CELL_AW      = $clog2(MAX_X_POINTS * MAX_Y_POINTS);
	localparam int FRAC_W       = 17;
	localparam int FRAC_Q_W     = 16;
	localparam int ACC_W        = 64;

	typedef enum logic [1:0] {
		OP_LOOKUP  = 2'd0,
		OP_WR_X    = 2'd1,
		OP_WR_Y    = 2'd2,
		OP_WR_CELL = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_ORDER = 2'd2,
		STAT_MODE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_MAP_MODE = 2'd0,
		CFG_X_POINTS = 2'd1,
		CFG_Y_POINTS = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ALU_NOP,
		ALU_MUL_LOAD,
		ALU_MUL_STEP,
		ALU_DIV_LOAD,
		ALU_DIV_STEP
	} alu_cmd_t;

	typedef struct packed {
		alu_cmd_t          cmd;
		logic [ACC_W-1:0]  a;
		logic [ACC_W-1:0]  b;
		logic [FRAC_W-1:0] f;
	} alu_req_t;

	typedef struct packed {
		logic             we;
		logic             sel;
		logic [IDX_W-1:0] addr;
		logic [31:0]      data;
	} axis_wr_t;

	typedef struct packed {
		logic               we;
		logic [CELL_AW-1:0] addr;
		logic [31:0]        data;
	} cell_wr_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP,
		S_A_CK0, S_A_CKN, S_A_SRCH, S_A_SCMP, S_A_LO, S_A_HI, S_A_DIV, S_A_DQ, S_A_DONE,
		S_C_RA, S_C_RB, S_C_LOAD, S_C_MUL, S_C_MEND, S_C_RC, S_C_RD, S_C_LOAD2,
		S_W_CKP, S_W_CKN,
		S_FIN
	} state_t;

	function automatic logic [CNT_W-1:0] eff_count(logic [CNT_W-1:0] r, logic [CNT_W-1:0] mx);
		logic [CNT_W-1:0] c;
		c = r;
		if (r == '0) c = CNT_W'(1);
		else if (r > mx) c = mx;
		return c;
	endfunction

	function automatic logic [CELL_AW-1:0] cell_addr(logic [IDX_W-1:0] row,
			logic [IDX_W-1:0] col, logic [CNT_W-1:0] cnt);
		logic [CELL_AW+1:0] p;
		p = (CELL_AW+2)'(row) * (CELL_AW+2)'(cnt) + (CELL_AW+2)'(col);
		return p[CELL_AW-1:0];
	endfunction

endpackage

// ----- rtl/cmap_axes.sv -----
// X and Y breakpoint registers with one registered read port and one write port.
module cmap_axes import cmap_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_sel,
	input  logic [IDX_W-1:0] rd_addr,
	input  axis_wr_t         wr,
	output logic [31:0]      rd_data
);
	logic [31:0] x_q [MAX_X_POINTS];
	logic [31:0] y_q [MAX_Y_POINTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_X_POINTS; i++) x_q[i] <= 32'(i);
			for (int i = 0; i < MAX_Y_POINTS; i++) y_q[i] <= 32'(i);
		end else if (wr.we) begin
			if (wr.sel) y_q[wr.addr] <= wr.data;
			else x_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= rd_sel ? y_q[rd_addr] : x_q[rd_addr];
	end
endmodule

// ----- rtl/cmap_cells.sv -----
// Cell memory with per-entry valid bits so unwritten cells read as zero.
module cmap_cells import cmap_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [CELL_AW-1:0] rd_addr,
	input  cell_wr_t           wr,
	output logic [31:0]        rd_data
);
	localparam int DEPTH = MAX_X_POINTS * MAX_Y_POINTS;

	logic [31:0]      mem [DEPTH];
	logic [DEPTH-1:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.we) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.we) mem[wr.addr] <= wr.data;
		rd_data <= valid_q[rd_addr] ? mem[rd_addr] : 32'd0;
	end
endmodule

// ----- rtl/cmap_alu.sv -----
// Shared shift-add multiplier and restoring divider, one step per cycle.
module cmap_alu import cmap_pkg::*; (
	input  logic                clk,
	input  alu_req_t            req,
	output logic [ACC_W-1:0]    acc,
	output logic [FRAC_Q_W-1:0] quot
);
	logic [ACC_W-1:0]    acc_q;
	logic [ACC_W-1:0]    d_q;
	logic [FRAC_W-1:0]   f_q;
	logic [33:0]         rem_q;
	logic [32:0]         den_q;
	logic [FRAC_Q_W-1:0] quot_q;
	logic [33:0]         rem2;

	assign rem2 = {rem_q[32:0], 1'b0};

	always_ff @(posedge clk) begin
		case (req.cmd)
			ALU_MUL_LOAD: begin
				acc_q <= req.a << FRAC_Q_W;
				d_q   <= req.b - req.a;
				f_q   <= req.f;
			end
			ALU_MUL_STEP: begin
				if (f_q[0]) acc_q <= acc_q + d_q;
				d_q <= d_q << 1;
				f_q <= f_q >> 1;
			end
			ALU_DIV_LOAD: begin
				rem_q  <= req.a[33:0];
				den_q  <= req.b[32:0];
				quot_q <= '0;
			end
			ALU_DIV_STEP: begin
				// restore unless the shifted remainder covers the divisor
				if (rem2 >= {1'b0, den_q}) begin
					rem_q  <= rem2 - {1'b0, den_q};
					quot_q <= {quot_q[FRAC_Q_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem2;
					quot_q <= {quot_q[FRAC_Q_W-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign acc  = acc_q;
	assign quot = quot_q;
endmodule

// ----- rtl/interpolated_calibration_map_core.sv -----
// Top level: sequencer for axis writes, cell writes and interpolated lookups.
//
// Channel   Dir  Fields (low bit first)
// s_*       in   operation, lookup_x, lookup_y, index_x, index_y, write_value
// m_*       out  interpolated_value, status
// cfg_*     in   index 0 map_mode, 1 x_points, 2 y_points
//
// A lookup runs the binary search (one probe per S_A_SRCH/S_A_SCMP pair)
// and a restoring divide on each axis looked up, then one shift-add multiply
// per linear step. The multiplier and divider share one unit. Reset clears
// control state; axes come up as entry i = i, cells as zero. A result
// waiting on m_tready holds the sequencer in its final state; s_tready is
// high only when idle.
module interpolated_calibration_map_core import cmap_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [1:0] operation, [33:2] lookup_x, [65:34] lookup_y, [69:66] index_x,
	// [73:70] index_y, [105:74] write_value, [111:106] zero
	input  logic [111:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [47:0] interpolated_value, [49:48] status, [55:50] zero
	output logic [55:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [4:0]   cfg_data
);
	state_t state_q, state_d;

	logic             map_mode_q;
	logic [CNT_W-1:0] x_points_q, y_points_q, xc, yc, cnt_cur;

	op_t               op_q;
	logic signed [31:0] vx_q, vy_q, wv_q, v_cur, ax_d, lo_val_q;
	logic [IDX_W-1:0]  ix_q, iy_q, idx_cur;
	logic              sel_q;
	logic [CNT_W-1:0]  lo_q, hi_q, mid, cnt_q;
	logic [FRAC_W-1:0] frac_q, fx_q, fy_q;
	logic [IDX_W-1:0]  xlo_q, xhi_q, ylo_q, yhi_q;
	logic [31:0]       cell_a_q, cell_d;
	logic [ACC_W-1:0]  r0_q, acc;
	logic [1:0]        ph_q;
	logic [47:0]       res_q;
	status_t           st_q;
	logic [FRAC_Q_W-1:0] quot;
	logic signed [32:0] num, den;

	logic             ax_rd_sel;
	logic [IDX_W-1:0] ax_rd_addr;
	axis_wr_t         ax_wr;
	logic [CELL_AW-1:0] cell_rd_addr;
	cell_wr_t         cell_wr;
	alu_req_t         alu_req;

	logic        m_tvalid_q;
	logic [55:0] m_tdata_q;

	assign xc      = eff_count(x_points_q, CNT_W'(MAX_X_POINTS));
	assign yc      = eff_count(y_points_q, CNT_W'(MAX_Y_POINTS));
	assign cnt_cur = sel_q ? yc : xc;
	assign v_cur   = sel_q ? vy_q : vx_q;
	assign idx_cur = sel_q ? iy_q : ix_q;
	assign mid     = CNT_W'((CNT_W+1)'(lo_q) + (CNT_W+1)'(hi_q) >> 1);
	assign num     = {v_cur[31], v_cur} - {lo_val_q[31], lo_val_q};
	assign den     = {ax_d[31], ax_d} - {lo_val_q[31], lo_val_q};

	cmap_axes u_axes (
		.clk(clk), .arst_n(arst_n), .rd_sel(ax_rd_sel), .rd_addr(ax_rd_addr),
		.wr(ax_wr), .rd_data(ax_d)
	);

	cmap_cells u_cells (
		.clk(clk), .arst_n(arst_n), .rd_addr(cell_rd_addr), .wr(cell_wr),
		.rd_data(cell_d)
	);

	cmap_alu u_alu (.clk(clk), .req(alu_req), .acc(acc), .quot(quot));

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_mode_q <= 1'b0;
			x_points_q <= CNT_W'(16);
			y_points_q <= CNT_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAP_MODE: map_mode_q <= cfg_data[0];
				CFG_X_POINTS: x_points_q <= cfg_data;
				CFG_Y_POINTS: y_points_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (s_tvalid) state_d = S_DISP;
			S_DISP: begin
				case (op_q)
					OP_LOOKUP: state_d = S_A_CK0;
					OP_WR_X: state_d = ({1'b0, ix_q} >= xc) ? S_FIN : S_W_CKP;
					OP_WR_Y: state_d = (!map_mode_q || {1'b0, iy_q} >= yc) ? S_FIN : S_W_CKP;
					default: state_d = S_FIN;
				endcase
			end
			S_A_CK0: state_d = (cnt_cur <= CNT_W'(1) || v_cur <= ax_d) ? S_A_DONE : S_A_CKN;
			S_A_CKN: state_d = (v_cur >= ax_d) ? S_A_DONE : S_A_SRCH;
			S_A_SRCH: state_d = (hi_q - lo_q > CNT_W'(1)) ? S_A_SCMP : S_A_LO;
			S_A_SCMP: state_d = S_A_SRCH;
			S_A_LO: state_d = S_A_HI;
			S_A_HI: state_d = (den <= 0 || num <= 0 || num >= den) ? S_A_DONE : S_A_DIV;
			S_A_DIV: if (cnt_q == CNT_W'(FRAC_Q_W - 1)) state_d = S_A_DQ;
			S_A_DQ: state_d = S_A_DONE;
			S_A_DONE: state_d = (map_mode_q && !sel_q) ? S_A_CK0 : S_C_RA;
			S_C_RA: state_d = S_C_RB;
			S_C_RB: state_d = S_C_LOAD;
			S_C_LOAD: state_d = S_C_MUL;
			S_C_MUL: if (cnt_q == CNT_W'(FRAC_W - 1)) state_d = S_C_MEND;
			S_C_MEND: begin
				if (ph_q == 2'd0) state_d = map_mode_q ? S_C_RC : S_FIN;
				else if (ph_q == 2'd1) state_d = S_C_LOAD2;
				else state_d = S_FIN;
			end
			S_C_RC: state_d = S_C_RD;
			S_C_RD: state_d = S_C_LOAD;
			S_C_LOAD2: state_d = S_C_MUL;
			S_W_CKP: state_d = (idx_cur != '0 && wv_q <= ax_d) ? S_FIN : S_W_CKN;
			S_W_CKN: state_d = S_FIN;
			S_FIN: if (!m_tvalid_q || m_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory addresses, writes and unit commands
	always_comb begin
		ax_rd_sel    = sel_q;
		ax_rd_addr   = '0;
		ax_wr        = '0;
		cell_rd_addr = cell_addr(ylo_q, xlo_q, xc);
		cell_wr      = '0;
		alu_req      = '0;
		alu_req.cmd  = ALU_NOP;
		case (state_q)
			S_DISP: begin
				ax_rd_sel  = (op_q == OP_WR_Y);
				ax_rd_addr = (op_q == OP_WR_Y) ? iy_q - 1'b1 : (op_q == OP_WR_X) ? ix_q - 1'b1 : '0;
				if (op_q == OP_WR_CELL && {1'b0, ix_q} < xc
						&& (!map_mode_q || {1'b0, iy_q} < yc)) begin
					cell_wr.we   = 1'b1;
					cell_wr.addr = cell_addr(map_mode_q ? iy_q : '0, ix_q, xc);
					cell_wr.data = wv_q;
				end
			end
			S_A_CK0: ax_rd_addr = IDX_W'(cnt_cur - 1'b1);
			S_A_SRCH: ax_rd_addr = (hi_q - lo_q > CNT_W'(1)) ? mid[IDX_W-1:0] : lo_q[IDX_W-1:0];
			S_A_LO: ax_rd_addr = hi_q[IDX_W-1:0];
			S_A_HI: begin
				alu_req.cmd = ALU_DIV_LOAD;
				alu_req.a   = ACC_W'(num[31:0]);
				alu_req.b   = ACC_W'(den[31:0]);
			end
			S_A_DIV: alu_req.cmd = ALU_DIV_STEP;
			S_A_DONE: begin
				ax_rd_sel  = 1'b1;
				ax_rd_addr = '0;
			end
			S_C_RB: cell_rd_addr = cell_addr(ylo_q, xhi_q, xc);
			S_C_LOAD: begin
				alu_req.cmd = ALU_MUL_LOAD;
				alu_req.a   = ACC_W'(signed'(cell_a_q));
				alu_req.b   = ACC_W'(signed'(cell_d));
				alu_req.f   = fx_q;
			end
			S_C_MUL: alu_req.cmd = ALU_MUL_STEP;
			S_C_RC: cell_rd_addr = cell_addr(yhi_q, xlo_q, xc);
			S_C_RD: cell_rd_addr = cell_addr(yhi_q, xhi_q, xc);
			S_C_LOAD2: begin
				alu_req.cmd = ALU_MUL_LOAD;
				alu_req.a   = r0_q;
				alu_req.b   = acc;
				alu_req.f   = fy_q;
			end
			S_W_CKP: ax_rd_addr = idx_cur + 1'b1;
			S_W_CKN: begin
				if (!({1'b0, idx_cur} + 1'b1 < cnt_cur && wv_q >= ax_d)) begin
					ax_wr.we   = 1'b1;
					ax_wr.sel  = sel_q;
					ax_wr.addr = idx_cur;
					ax_wr.data = wv_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q  <= op_t'(s_tdata[1:0]);
				vx_q  <= s_tdata[33:2];
				vy_q  <= s_tdata[65:34];
				ix_q  <= s_tdata[69:66];
				iy_q  <= s_tdata[73:70];
				wv_q  <= s_tdata[105:74];
			end
			S_DISP: begin
				res_q <= '0;
				sel_q <= (op_q == OP_WR_Y);
				ylo_q <= '0;
				yhi_q <= '0;
				fy_q  <= '0;
				ph_q  <= 2'd0;
				case (op_q)
					OP_WR_X: st_q <= ({1'b0, ix_q} >= xc) ? STAT_RANGE : STAT_OK;
					OP_WR_Y: begin
						if (!map_mode_q) st_q <= STAT_MODE;
						else if ({1'b0, iy_q} >= yc) st_q <= STAT_RANGE;
						else st_q <= STAT_OK;
					end
					OP_WR_CELL: begin
						if ({1'b0, ix_q} >= xc || (map_mode_q && {1'b0, iy_q} >= yc))
							st_q <= STAT_RANGE;
						else
							st_q <= STAT_OK;
					end
					default: st_q <= STAT_OK;
				endcase
			end
			S_A_CK0: begin
				lo_q   <= '0;
				hi_q   <= '0;
				frac_q <= '0;
			end
			S_A_CKN: begin
				frac_q <= '0;
				if (v_cur >= ax_d) begin
					lo_q <= cnt_cur - 1'b1;
					hi_q <= cnt_cur - 1'b1;
				end else begin
					lo_q <= '0;
					hi_q <= cnt_cur - 1'b1;
				end
			end
			S_A_SCMP: begin
				if (v_cur < ax_d) hi_q <= mid;
				else lo_q <= mid;
			end
			S_A_LO: lo_val_q <= ax_d;
			S_A_HI: begin
				cnt_q  <= '0;
				frac_q <= (den > 0 && num > 0 && num >= den) ? FRAC_W'(1 << FRAC_Q_W) : '0;
			end
			S_A_DIV: cnt_q <= cnt_q + 1'b1;
			S_A_DQ: frac_q <= FRAC_W'(quot);
			S_A_DONE: begin
				if (sel_q) begin
					ylo_q <= lo_q[IDX_W-1:0];
					yhi_q <= hi_q[IDX_W-1:0];
					fy_q  <= frac_q;
				end else begin
					xlo_q <= lo_q[IDX_W-1:0];
					xhi_q <= hi_q[IDX_W-1:0];
					fx_q  <= frac_q;
				end
				sel_q <= 1'b1;
			end
			S_C_RB, S_C_RD: cell_a_q <= cell_d;
			S_C_LOAD, S_C_LOAD2: cnt_q <= '0;
			S_C_MUL: cnt_q <= cnt_q + 1'b1;
			S_C_MEND: begin
				ph_q <= ph_q + 1'b1;
				if (ph_q == 2'd0) begin
					r0_q  <= acc;
					res_q <= acc[47:0];
				end else if (ph_q == 2'd2) begin
					res_q <= acc[63:16];
				end
			end
			S_W_CKP: if (idx_cur != '0 && wv_q <= ax_d) st_q <= STAT_ORDER;
			S_W_CKN: if ({1'b0, idx_cur} + 1'b1 < cnt_cur && wv_q >= ax_d) st_q <= STAT_ORDER;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_FIN && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!m_tvalid_q || m_tready))
			m_tdata_q <= {6'd0, st_q, res_q};
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
endmodule
